>>> rtl/indexed_list_store_unit_defines.svh
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Shared concurrent assertion forms, clocked on aclk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_UNIT_DEFINES_SVH
`define INDEXED_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ILS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("indexed list store: same-cycle check failed");

// Next-cycle implication.
`define ILS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("indexed list store: next-cycle check failed");

`endif

>>> rtl/ils_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store package
// Command and status codes, and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned POSIN_W  = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET      = 3'd0,
        CMD_ADD_HEAD = 3'd1,
        CMD_ADD_TAIL = 3'd2,
        CMD_INSERT   = 3'd3,
        CMD_DELETE   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // What each cell does with its entry this cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

>>> rtl/indexed_list_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store unit
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
//
//   channel  direction  ports                                     meaning
//   s_       in         s_cmd, s_position, s_item_value           one command
//   m_       out        m_read_value, m_status, m_count_now       one result
//
// A command transfer is registered in the read stage and then in the output
// register before its result appears on the m_ channel; a new command may
// transfer in every cycle unless the m_ channel stalls. Each cell drives its
// entry onto a bus, ORed in registered groups of GROUP_SIZE and then across them.
// Reset (aresetn low, synchronous) empties the list and the result path; the
// entry storage itself is not cleared and is never read before it is written.
// A stalled m_ channel holds the result; s_ready then drops once the read
// stage is also full.
// ----------------------------------------------------------------------------
`include "indexed_list_store_unit_defines.svh"

module indexed_list_store_unit #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ils_pkg::CMD_W-1:0]    s_cmd,
    input  logic [ils_pkg::POSIN_W-1:0]  s_position,
    input  logic signed [31:0]           s_item_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_read_value,
    output logic [ils_pkg::STATUS_W-1:0] m_status,
    output logic [ils_pkg::COUNT_W-1:0]  m_count_now
);

    // Count holds 0..CAPACITY; position compares run at a width that
    // holds both the count and the 8-bit command position.
    localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
    localparam int unsigned POS_W      = (CNT_W > ils_pkg::POSIN_W) ? CNT_W : ils_pkg::POSIN_W;
    localparam int unsigned GROUP_SIZE = 16;
    localparam int unsigned NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int unsigned PAD_CELLS  = NUM_GROUPS * GROUP_SIZE;
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    logic s_accept;
    logic red_adv;

    // List length.
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Command decode.
    logic [POS_W-1:0]    pos_ext;
    logic [POS_W-1:0]    cnt_ext;
    logic [POS_W-1:0]    ins_pos;
    logic [POS_W-1:0]    op_pos;
    ils_pkg::cell_op_t   dec_op;
    ils_pkg::status_t    dec_status;
    logic                dec_get;
    logic                dec_hit;
    logic [CNT_W-1:0]    dec_count;
    ils_pkg::cell_ctrl_t cell_ctrl;

    // Cell row and read bus.
    logic [ils_pkg::DATA_W-1:0] cell_entry [CAPACITY];
    logic [ils_pkg::DATA_W-1:0] cell_read  [PAD_CELLS];
    logic [ils_pkg::DATA_W-1:0] group_or   [NUM_GROUPS];

    // Read stage: one command whose bus value is being reduced.
    logic                       red_valid_reg;
    logic                       red_get_reg;
    logic                       red_hit_reg;
    ils_pkg::status_t           red_status_reg;
    logic [ils_pkg::COUNT_W-1:0] red_count_reg;
    logic [ils_pkg::DATA_W-1:0] group_or_reg [NUM_GROUPS];
    logic [ils_pkg::DATA_W-1:0] tree_or;

    // Output register.
    logic                         m_valid_reg;
    logic [ils_pkg::DATA_W-1:0]   m_read_value_reg;
    logic [ils_pkg::STATUS_W-1:0] m_status_reg;
    logic [ils_pkg::COUNT_W-1:0]  m_count_reg;

    // The read stage moves on when the output register is free or being
    // emptied; a new command may enter as the read stage moves on.
    assign red_adv  = red_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !red_valid_reg || red_adv;
    assign s_accept = s_valid && s_ready;

    assign pos_ext = POS_W'(s_position);
    assign cnt_ext = POS_W'(cnt_reg);

    always_comb begin
        dec_op     = ils_pkg::CELL_HOLD;
        dec_status = ils_pkg::ST_IGNORED;
        dec_get    = 1'b0;
        dec_hit    = 1'b0;
        dec_count  = cnt_reg;
        ins_pos    = pos_ext;
        op_pos     = pos_ext;
        case (s_cmd)
            ils_pkg::CMD_GET: begin
                dec_get    = 1'b1;
                dec_hit    = (pos_ext < cnt_ext);
                dec_status = dec_hit ? ils_pkg::ST_DONE : ils_pkg::ST_IGNORED;
            end
            ils_pkg::CMD_ADD_HEAD, ils_pkg::CMD_ADD_TAIL, ils_pkg::CMD_INSERT: begin
                if (s_cmd == ils_pkg::CMD_ADD_HEAD) begin
                    ins_pos = '0;
                end else if (s_cmd == ils_pkg::CMD_ADD_TAIL) begin
                    ins_pos = cnt_ext;
                end
                op_pos = ins_pos;
                // The range check takes priority over the full check.
                if (ins_pos > cnt_ext) begin
                    dec_status = ils_pkg::ST_IGNORED;
                end else if (cnt_reg == CAP_COUNT) begin
                    dec_status = ils_pkg::ST_FULL;
                end else begin
                    dec_status = ils_pkg::ST_DONE;
                    dec_op     = ils_pkg::CELL_INSERT;
                    dec_count  = cnt_reg + CNT_W'(1);
                end
            end
            ils_pkg::CMD_DELETE: begin
                if (pos_ext < cnt_ext) begin
                    dec_status = ils_pkg::ST_DONE;
                    dec_op     = ils_pkg::CELL_DELETE;
                    dec_count  = cnt_reg - CNT_W'(1);
                end
            end
            default: begin
                dec_status = ils_pkg::ST_IGNORED;
            end
        endcase
    end

    // Cells change only on an accepted transfer.
    assign cell_ctrl.op    = s_accept ? dec_op : ils_pkg::CELL_HOLD;
    assign cell_ctrl.value = s_item_value;

    assign cnt_next = s_accept ? dec_count : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // The row of cells. The ends see zero beyond the row; nothing past
    // the count is ever read back, so the fill value does not matter.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ils_pkg::DATA_W-1:0] left_in;
        logic [ils_pkg::DATA_W-1:0] right_in;

        if (i == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_inner_l
            assign left_in = cell_entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_inner_r
            assign right_in = cell_entry[i+1];
        end

        ils_cell #(
            .INDEX (i),
            .POS_W (POS_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .pos        (op_pos),
            .left_data  (left_in),
            .right_data (right_in),
            .entry_data (cell_entry[i]),
            .read_data  (cell_read[i])
        );
    end

    for (genvar i = CAPACITY; i < PAD_CELLS; i++) begin : g_pad
        assign cell_read[i] = '0;
    end

    // First level of the read tree: OR each group of cells.
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
        always_comb begin
            group_or[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                group_or[g] = group_or[g] | cell_read[g*GROUP_SIZE + k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_valid_reg <= 1'b0;
        end else if (s_accept) begin
            red_valid_reg <= 1'b1;
        end else if (red_adv) begin
            red_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            red_get_reg    <= dec_get;
            red_hit_reg    <= dec_hit;
            red_status_reg <= dec_status;
            red_count_reg  <= ils_pkg::COUNT_W'(dec_count);
            for (int g = 0; g < NUM_GROUPS; g++) begin
                group_or_reg[g] <= group_or[g];
            end
        end
    end

    // Second level of the read tree, across the registered groups.
    always_comb begin
        tree_or = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            tree_or = tree_or | group_or_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (red_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // A get past the end reads as all ones; other commands read zero.
    always_ff @(posedge aclk) begin
        if (red_adv) begin
            if (red_get_reg) begin
                m_read_value_reg <= red_hit_reg ? tree_or : '1;
            end else begin
                m_read_value_reg <= '0;
            end
            m_status_reg <= red_status_reg;
            m_count_reg  <= red_count_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_count_now  = m_count_reg;

    // The list never grows past its capacity.
    `ILS_ASSERT_SAME(a_count_bound, 1'b1, cnt_reg <= CAP_COUNT)
    // A completed insert grows the list by exactly one entry.
    `ILS_ASSERT_NEXT(a_insert_grows, s_accept && (dec_op == ils_pkg::CELL_INSERT), cnt_reg == $past(cnt_reg) + CNT_W'(1))
    // An add at the tail on a full list is reported as dropped.
    `ILS_ASSERT_NEXT(a_full_drop, s_accept && (cnt_reg == CAP_COUNT) && (s_cmd == ils_pkg::CMD_ADD_TAIL), red_status_reg == ils_pkg::ST_FULL)
    // A pending read stage always reaches an empty output register.
    `ILS_ASSERT_NEXT(a_read_moves, red_valid_reg && !m_valid_reg, m_valid_reg)

endmodule

>>> rtl/ils_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one list entry; shifts from its left or right neighbor on insert
// and delete, and offers its entry on the read bus when addressed.
// ----------------------------------------------------------------------------
module ils_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned POS_W = 8
) (
    input  logic                       aclk,
    input  ils_pkg::cell_ctrl_t        ctrl,
    input  logic [POS_W-1:0]           pos,
    input  logic [ils_pkg::DATA_W-1:0] left_data,
    input  logic [ils_pkg::DATA_W-1:0] right_data,
    output logic [ils_pkg::DATA_W-1:0] entry_data,
    output logic [ils_pkg::DATA_W-1:0] read_data
);

    localparam logic [POS_W-1:0] MY_INDEX = POS_W'(INDEX);

    logic [ils_pkg::DATA_W-1:0] entry_reg;
    logic [ils_pkg::DATA_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            ils_pkg::CELL_INSERT: begin
                // Cells above the insert point take their lower neighbor.
                if (MY_INDEX > pos) begin
                    entry_next = left_data;
                end else if (MY_INDEX == pos) begin
                    entry_next = ctrl.value;
                end
            end
            ils_pkg::CELL_DELETE: begin
                if (MY_INDEX >= pos) begin
                    entry_next = right_data;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_data = entry_reg;
    assign read_data  = (MY_INDEX == pos) ? entry_reg : '0;

endmodule

>>> tb/indexed_list_store_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store unit testbench
// Drives get, add, insert and delete commands into the list store, predicts
// every result from a shadow copy of the list, and checks each result transfer.
// ----------------------------------------------------------------------------
//
// The stimulus has two parts. A short directed list runs the corner cases
// first: reads and deletes on an empty list, unused command codes, inserts at
// and past the end, the full list with its drop and its ignored index, and the
// largest positions. Rows whose result is obvious carry it typed in; the other
// rows, and all of the random traffic that follows, are checked against the
// shadow list kept in this module.
//
// The random traffic runs in phases. Each phase favors filling, draining or a
// balanced mix, so the list swings between empty and full many times. Both
// sides of the block idle at random, some phases run with no idling at all,
// and once the result side holds off for a long stretch so that the block
// fills up and pushes back on the command side.
// ----------------------------------------------------------------------------
module indexed_list_store_unit_test;

    localparam int unsigned CAPACITY      = 128;
    localparam time         CLK_HALF      = 4ns;
    localparam int unsigned RESET_CYCLES  = 10;
    // The directed rows send 280 commands; together they make about 1550.
    localparam int unsigned RANDOM_ITEMS  = 1270;
    localparam int unsigned PHASE_LEN     = 150;
    // Item index at which the result side starts its long hold-off.
    localparam int unsigned HOLD_AT_ITEM  = 500;
    localparam int unsigned HOLD_CYCLES   = 300;
    // Quiet cycles after the last expected result.
    localparam int unsigned TAIL_CYCLES   = 16;
    localparam int unsigned LIMIT_CYCLES  = 200000;

    // Command codes the block does not implement; they must be ignored.
    localparam logic [ils_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [ils_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    // One result transfer, as the m_ channel presents it.
    typedef struct packed {
        logic [ils_pkg::DATA_W-1:0]   rv;
        logic [ils_pkg::STATUS_W-1:0] st;
        logic [ils_pkg::COUNT_W-1:0]  cnt;
    } list_result_t;

    // A row of directed stimulus. A row with reps above one is sent that many
    // times, each time with a random value.
    typedef struct {
        logic [ils_pkg::CMD_W-1:0]   op;
        logic [ils_pkg::POSIN_W-1:0] pos;
        logic [ils_pkg::DATA_W-1:0]  val;
        int unsigned                 reps;
        bit                          typed;
        list_result_t                known;
    } directed_row_t;

    // Traffic mix of one random phase.
    typedef enum int unsigned {
        MIX_FILL     = 0,
        MIX_DRAIN    = 1,
        MIX_BALANCED = 2
    } traffic_mix_t;

    // Clock, reset and the block's ports. Every input has a known value from
    // time zero.
    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic [ils_pkg::CMD_W-1:0]      s_cmd        = '0;
    logic [ils_pkg::POSIN_W-1:0]    s_position   = '0;
    logic signed [31:0]             s_item_value = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic signed [31:0]             m_read_value;
    logic [ils_pkg::STATUS_W-1:0]   m_status;
    logic [ils_pkg::COUNT_W-1:0]    m_count_now;

    // Shadow copy of the list. Only positions below shadow_count are read.
    logic [ils_pkg::DATA_W-1:0]     shadow_entries [CAPACITY];
    int unsigned                    shadow_count = 0;

    // Results owed by the block, oldest first.
    list_result_t                   pending_results [$];
    directed_row_t                  directed_rows [$];

    int unsigned                    error_count  = 0;
    int unsigned                    cycle_count  = 0;
    // Set by the stimulus, read by both sides: no idling in this phase.
    bit                             no_idle      = 1'b0;
    // Set by the stimulus, cleared by the result side once it has held off.
    bit                             hold_pending = 1'b0;

    indexed_list_store_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_position  (s_position),
        .s_item_value(s_item_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_value(m_read_value),
        .m_status    (m_status),
        .m_count_now (m_count_now)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // Watchdog. The limit is many times the slowest correct run: every item
    // waiting out the longest gap on both sides plus the long hold-off.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shadow list
    // ------------------------------------------------------------------------

    // Inserts before position at. The index check comes ahead of the full
    // check, so an index past the end of a full list is ignored, not dropped.
    function automatic logic [ils_pkg::STATUS_W-1:0] shadow_insert(
        int unsigned at, logic [ils_pkg::DATA_W-1:0] val);
        if (at > shadow_count) begin
            return ils_pkg::ST_IGNORED;
        end
        if (shadow_count >= CAPACITY) begin
            return ils_pkg::ST_FULL;
        end
        for (int unsigned i = shadow_count; i > at; i--) begin
            shadow_entries[i] = shadow_entries[i - 1];
        end
        shadow_entries[at] = val;
        shadow_count++;
        return ils_pkg::ST_DONE;
    endfunction

    // Applies one command to the shadow list and returns the result it owes.
    function automatic list_result_t predict_list_result(
        logic [ils_pkg::CMD_W-1:0] op, logic [ils_pkg::POSIN_W-1:0] pos,
        logic [ils_pkg::DATA_W-1:0] val);
        list_result_t res;
        int unsigned  at;
        res = '{rv: '0, st: ils_pkg::ST_DONE, cnt: '0};
        at  = pos;
        case (op)
            ils_pkg::CMD_GET: begin
                if (at < shadow_count) begin
                    res.rv = shadow_entries[at];
                end else begin
                    res.rv = '1;
                    res.st = ils_pkg::ST_IGNORED;
                end
            end
            ils_pkg::CMD_ADD_HEAD: begin
                res.st = shadow_insert(0, val);
            end
            ils_pkg::CMD_ADD_TAIL: begin
                res.st = shadow_insert(shadow_count, val);
            end
            ils_pkg::CMD_INSERT: begin
                res.st = shadow_insert(at, val);
            end
            ils_pkg::CMD_DELETE: begin
                if (at >= shadow_count) begin
                    res.st = ils_pkg::ST_IGNORED;
                end else begin
                    for (int unsigned i = at; i + 1 < shadow_count; i++) begin
                        shadow_entries[i] = shadow_entries[i + 1];
                    end
                    shadow_count--;
                end
            end
            default: begin
                // Unused codes change nothing and read back zero.
                res.st = ils_pkg::ST_IGNORED;
            end
        endcase
        res.cnt = shadow_count[ils_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_row(input logic [ils_pkg::CMD_W-1:0] op,
                           input logic [ils_pkg::POSIN_W-1:0] pos,
                           input logic [ils_pkg::DATA_W-1:0] val, input int unsigned reps,
                           input bit typed, input logic [ils_pkg::DATA_W-1:0] rv,
                           input logic [ils_pkg::STATUS_W-1:0] st,
                           input logic [ils_pkg::COUNT_W-1:0] cnt);
        directed_row_t row;
        row.op    = op;
        row.pos   = pos;
        row.val   = val;
        row.reps  = reps;
        row.typed = typed;
        row.known = '{rv: rv, st: st, cnt: cnt};
        directed_rows.push_back(row);
    endtask

    // Values lean on the sign extremes, zero and all ones.
    function automatic logic [ils_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Command choice for a phase. The bounds are cumulative percentages for
    // get, add head, add tail, insert and delete, in code order; the rest of
    // the range picks any 3-bit code, unused ones included.
    function automatic logic [ils_pkg::CMD_W-1:0] random_cmd(traffic_mix_t mix);
        int unsigned bounds [3][5];
        int unsigned roll;
        bounds = '{'{10, 35, 60, 92, 97}, '{15, 20, 25, 30, 95}, '{25, 37, 49, 62, 95}};
        roll   = $urandom_range(0, 99);
        for (int unsigned k = 0; k < 5; k++) begin
            if (roll < bounds[mix][k]) begin
                return ils_pkg::cmd_t'(k);
            end
        end
        return ils_pkg::CMD_W'($urandom_range(0, 7));
    endfunction

    // Positions mostly land inside the list or right at its end, some near the
    // boundary, and some anywhere in the 8-bit range.
    function automatic logic [ils_pkg::POSIN_W-1:0] random_position();
        int unsigned roll;
        int unsigned low;
        roll = $urandom_range(0, 99);
        low  = (shadow_count > 0) ? shadow_count - 1 : 0;
        if (roll < 70) begin
            return ils_pkg::POSIN_W'($urandom_range(0, shadow_count));
        end else if (roll < 85) begin
            return ils_pkg::POSIN_W'($urandom_range(low, shadow_count + 1));
        end
        return ils_pkg::POSIN_W'($urandom_range(0, 255));
    endfunction

    // Offers one command after a random gap and waits for its transfer. The
    // expected result is worked out at the transfer edge; a typed result, where
    // one is given, stands in for the predicted one.
    task automatic send_list_cmd(input logic [ils_pkg::CMD_W-1:0] op,
                                 input logic [ils_pkg::POSIN_W-1:0] pos,
                                 input logic [ils_pkg::DATA_W-1:0] val, input bit typed,
                                 input list_result_t known);
        int unsigned  gap;
        list_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= op;
        s_position   <= pos;
        s_item_value <= val;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predicted = predict_list_result(op, pos, val);
        pending_results.push_back(typed ? known : predicted);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Compares one result transfer with the oldest expectation.
    task automatic check_result();
        list_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: read_value %h status %0d count_now %0d",
                     $time, m_read_value, m_status, m_count_now);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (m_read_value !== want.rv) begin
            $display("%0t: read_value expected %h, got %h", $time, want.rv, m_read_value);
            error_count++;
        end
        if (m_status !== want.st) begin
            $display("%0t: status expected %0d, got %0d", $time, want.st, m_status);
            error_count++;
        end
        if (m_count_now !== want.cnt) begin
            $display("%0t: count_now expected %0d, got %0d", $time, want.cnt, m_count_now);
            error_count++;
        end
    endtask

    // The result side draws a stall before each transfer. When a hold-off is
    // asked for, it keeps ready low for a long stretch instead, while the
    // command side keeps offering items.
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_pending) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_pending = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 9);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            check_result();
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin : command_source
        traffic_mix_t               mix;
        directed_row_t              row;
        logic [ils_pkg::DATA_W-1:0] val;
        list_result_t               none;

        none = '{rv: '0, st: ils_pkg::ST_DONE, cnt: '0};
        mix  = MIX_BALANCED;

        // Each row gives the command, position, value, repeat count and
        // whether a result is typed in; the second line holds that result.

        // Empty list: reads, deletes and inserts past the end are ignored, and
        // so are the unused command codes.
        add_row(ils_pkg::CMD_GET,      8'd0,   32'd0,         1,   1'b1,
                '1,            ils_pkg::ST_IGNORED, 8'd0);
        add_row(ils_pkg::CMD_DELETE,   8'd0,   32'd0,         1,   1'b1,
                '0,            ils_pkg::ST_IGNORED, 8'd0);
        add_row(ils_pkg::CMD_INSERT,   8'd1,   32'h1234_5678, 1,   1'b1,
                '0,            ils_pkg::ST_IGNORED, 8'd0);
        add_row(CMD_UNUSED_FIRST,      8'd0,   32'h5A5A_5A5A, 1,   1'b1,
                '0,            ils_pkg::ST_IGNORED, 8'd0);
        add_row(CMD_UNUSED_LAST,       8'd255, 32'hFFFF_FFFF, 1,   1'b1,
                '0,            ils_pkg::ST_IGNORED, 8'd0);
        // Build [80000000, 00000001, 7FFFFFFF, FFFFFFFF] from all three add forms;
        // the insert at position two equals the count and appends.
        add_row(ils_pkg::CMD_ADD_TAIL, 8'd0,   32'h7FFF_FFFF, 1,   1'b1,
                '0,            ils_pkg::ST_DONE,    8'd1);
        add_row(ils_pkg::CMD_ADD_HEAD, 8'd0,   32'h8000_0000, 1,   1'b1,
                '0,            ils_pkg::ST_DONE,    8'd2);
        add_row(ils_pkg::CMD_INSERT,   8'd2,   32'hFFFF_FFFF, 1,   1'b1,
                '0,            ils_pkg::ST_DONE,    8'd3);
        add_row(ils_pkg::CMD_INSERT,   8'd1,   32'h0000_0001, 1,   1'b1,
                '0,            ils_pkg::ST_DONE,    8'd4);
        add_row(ils_pkg::CMD_GET,      8'd0,   32'd0,         1,   1'b1,
                32'h8000_0000, ils_pkg::ST_DONE,    8'd4);
        add_row(ils_pkg::CMD_GET,      8'd3,   32'd0,         1,   1'b1,
                32'hFFFF_FFFF, ils_pkg::ST_DONE,    8'd4);
        // Positions at and far past the end, then a delete and a read inside the list.
        add_row(ils_pkg::CMD_GET,      8'd4,   32'd0,         1,   1'b1,
                '1,            ils_pkg::ST_IGNORED, 8'd4);
        add_row(ils_pkg::CMD_GET,      8'd255, 32'd0,         1,   1'b1,
                '1,            ils_pkg::ST_IGNORED, 8'd4);
        add_row(ils_pkg::CMD_INSERT,   8'd255, 32'h0BAD_0BAD, 1,   1'b1,
                '0,            ils_pkg::ST_IGNORED, 8'd4);
        add_row(ils_pkg::CMD_DELETE,   8'd255, 32'd0,         1,   1'b1,
                '0,            ils_pkg::ST_IGNORED, 8'd4);
        add_row(ils_pkg::CMD_DELETE,   8'd4,   32'd0,         1,   1'b1,
                '0,            ils_pkg::ST_IGNORED, 8'd4);
        add_row(ils_pkg::CMD_DELETE,   8'd1,   32'd0,         1,   1'b1,
                '0,            ils_pkg::ST_DONE,    8'd3);
        add_row(ils_pkg::CMD_GET,      8'd1,   32'd0,         1,   1'b1,
                32'h7FFF_FFFF, ils_pkg::ST_DONE,    8'd3);
        // Fill to capacity, then every add form is dropped; an insert index past
        // the end of the full list is still only ignored.
        add_row(ils_pkg::CMD_ADD_TAIL, 8'd0,   32'd0,         125, 1'b0,
                '0,            ils_pkg::ST_DONE,    8'd0);
        add_row(ils_pkg::CMD_ADD_HEAD, 8'd0,   32'd0,         1,   1'b1,
                '0,            ils_pkg::ST_FULL,    8'd128);
        add_row(ils_pkg::CMD_INSERT,   8'd128, 32'd0,         1,   1'b1,
                '0,            ils_pkg::ST_FULL,    8'd128);
        add_row(ils_pkg::CMD_INSERT,   8'd129, 32'd0,         1,   1'b1,
                '0,            ils_pkg::ST_IGNORED, 8'd128);
        add_row(ils_pkg::CMD_ADD_TAIL, 8'd0,   32'd0,         1,   1'b1,
                '0,            ils_pkg::ST_FULL,    8'd128);
        add_row(ils_pkg::CMD_GET,      8'd127, 32'd0,         1,   1'b0,
                '0,            ils_pkg::ST_DONE,    8'd0);
        add_row(ils_pkg::CMD_GET,      8'd128, 32'd0,         1,   1'b1,
                '1,            ils_pkg::ST_IGNORED, 8'd128);
        add_row(ils_pkg::CMD_DELETE,   8'd127, 32'd0,         1,   1'b1,
                '0,            ils_pkg::ST_DONE,    8'd127);
        add_row(ils_pkg::CMD_INSERT,   8'd5,   32'h0F0F_0F0F, 1,   1'b1,
                '0,            ils_pkg::ST_DONE,    8'd128);
        // Drain from the head until empty.
        add_row(ils_pkg::CMD_DELETE,   8'd0,   32'd0,         128, 1'b0,
                '0,            ils_pkg::ST_DONE,    8'd0);
        add_row(ils_pkg::CMD_GET,      8'd0,   32'd0,         1,   1'b1,
                '1,            ils_pkg::ST_IGNORED, 8'd0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            for (int unsigned k = 0; k < row.reps; k++) begin
                val = (row.reps > 1) ? random_value() : row.val;
                send_list_cmd(row.op, row.pos, val, row.typed, row.known);
            end
        end

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                mix     = traffic_mix_t'($urandom_range(0, 2));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n == HOLD_AT_ITEM) begin
                hold_pending = 1'b1;
            end
            send_list_cmd(random_cmd(mix), random_position(), random_value(), 1'b0, none);
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        // Wait for every owed result, then watch for stray ones.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
